### hdl/ggw_pkg.sv
// Package for the greedy word wrap block: widths, character codes, command codes
// and the structs passed between the top level and the line tracker.
// No dependencies.
`default_nettype none
package ggw_pkg;

    localparam int MAX_LEN   = 4096;
    localparam int GLYPHS    = 256;

    localparam int CODE_W    = 8;
    localparam int ADV_W     = 8;
    localparam int MAXW_W    = 16;
    localparam int WIDTH_W   = 20;
    localparam int BREAK_W   = 12;
    localparam int POS_W     = $clog2(MAX_LEN);
    localparam int TABLE_AW  = $clog2(GLYPHS);

    localparam logic [CODE_W-1:0]  CODE_NEWLINE    = CODE_W'(10);
    localparam logic [CODE_W-1:0]  CODE_SPACE      = CODE_W'(32);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX       = {WIDTH_W{1'b1}};
    localparam logic [MAXW_W-1:0]  MAX_WIDTH_RESET = {MAXW_W{1'b1}};
    localparam logic [POS_W-1:0]   POS_LAST        = POS_W'(MAX_LEN - 1);

    typedef enum logic {
        CMD_TABLE_WRITE = 1'b0,
        CMD_CHAR        = 1'b1
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [CODE_W-1:0] code;
    } line_req_t;

    typedef struct packed {
        logic               hit;
        logic [BREAK_W-1:0] break_pos;
        logic [WIDTH_W-1:0] line_width;
    } line_res_t;

endpackage
`default_nettype wire

### hdl/ggw_if.sv
// Valid/ready channel interfaces for the greedy word wrap block.
// Depends on ggw_pkg.
`default_nettype none
interface ggw_char_if;
    import ggw_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CODE_W-1:0] code;
    logic [ADV_W-1:0]  advance;
    logic              start_req;

    modport source (output valid, cmd, code, advance, start_req, input ready);
    modport sink   (input valid, cmd, code, advance, start_req, output ready);
endinterface

interface ggw_break_if;
    import ggw_pkg::*;

    logic               valid;
    logic               ready;
    logic [BREAK_W-1:0] break_pos;
    logic [WIDTH_W-1:0] line_width;

    modport source (output valid, break_pos, line_width, input ready);
    modport sink   (input valid, break_pos, line_width, output ready);
endinterface

interface ggw_cfg_if;
    import ggw_pkg::*;

    logic              valid;
    logic              ready;
    logic [MAXW_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### hdl/ggw_line.sv
// Line tracker: running width, last-space mark and character position, with the
// combinational step that updates them and detects a break. Depends on ggw_pkg.
`default_nettype none
module ggw_line (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire ggw_pkg::line_req_t         req,
    input  wire logic [ggw_pkg::ADV_W-1:0]  adv,
    input  wire logic [ggw_pkg::MAXW_W-1:0] max_width,
    output ggw_pkg::line_res_t              res
);
    import ggw_pkg::*;

    logic [WIDTH_W-1:0] run_width_reg,   run_width_next;
    logic [WIDTH_W-1:0] space_width_reg, space_width_next;
    logic [POS_W-1:0]   space_pos_reg,   space_pos_next;
    logic               space_valid_reg, space_valid_next;
    logic [POS_W-1:0]   char_pos_reg,    char_pos_next;

    logic [WIDTH_W-1:0] base_width;
    logic [WIDTH_W-1:0] mark_width;
    logic [POS_W-1:0]   mark_pos;
    logic               mark_valid;
    logic [POS_W-1:0]   pos;
    logic [WIDTH_W:0]   sum;
    logic [WIDTH_W-1:0] sat;
    logic               hit;

    always_comb
    begin
        base_width = req.start ? '0   : run_width_reg;
        mark_width = req.start ? '0   : space_width_reg;
        mark_pos   = req.start ? '0   : space_pos_reg;
        mark_valid = req.start ? 1'b0 : space_valid_reg;
        pos        = req.start ? '0   : char_pos_reg;

        // take the mark at a space before adding its advance
        if (req.code == CODE_SPACE)
        begin
            mark_width = base_width;
            mark_pos   = pos;
            mark_valid = 1'b1;
        end

        sum = {1'b0, base_width} + (WIDTH_W + 1)'(adv);
        sat = sum[WIDTH_W] ? WIDTH_MAX : sum[WIDTH_W-1:0];
        hit = (req.code != CODE_NEWLINE) && mark_valid
              && (sat >= WIDTH_W'(max_width));

        space_width_next = mark_width;
        space_pos_next   = mark_pos;
        if (req.code == CODE_NEWLINE)
        begin
            run_width_next   = '0;
            space_valid_next = 1'b0;
        end
        else if (hit)
        begin
            run_width_next   = (sat >= mark_width) ? sat - mark_width : '0;
            space_valid_next = 1'b0;
        end
        else
        begin
            run_width_next   = sat;
            space_valid_next = mark_valid;
        end

        char_pos_next = (pos == POS_LAST) ? '0 : pos + POS_W'(1);

        res.hit        = hit;
        res.break_pos  = BREAK_W'(mark_pos);
        res.line_width = run_width_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_width_reg   <= '0;
            space_width_reg <= '0;
            space_pos_reg   <= '0;
            space_valid_reg <= 1'b0;
            char_pos_reg    <= '0;
        end
        else if (step)
        begin
            run_width_reg   <= run_width_next;
            space_width_reg <= space_width_next;
            space_pos_reg   <= space_pos_next;
            space_valid_reg <= space_valid_next;
            char_pos_reg    <= char_pos_next;
        end
    end

endmodule
`default_nettype wire

### hdl/greedy_word_wrap.sv
// Greedy word wrap top level: advance table, input stage, result register.
// Depends on ggw_pkg, ggw_if (ggw_char_if, ggw_break_if, ggw_cfg_if) and ggw_line.
//
// Usage:
//   chars  : items in. cmd = table write stores advance at entry code; cmd = char
//            processes code (start_req clears width, mark and position first).
//   breaks : one item out per character that forces a wrap, carrying the
//            position of the space that becomes a newline and the line width
//            left after the break.
//   cfg    : writes max_width; always ready. Write only while the block is idle.
// Path: a breaking character enters the input stage together with its table read,
//   and its break item enters the result register when that stage advances.
// Throughput: one item per cycle unless the input stage stalls, set by the single
//   table read port and the one add-and-compare step of the line tracker.
// Reset: width, mark, position and both pipeline stages clear; max_width
//   returns to 65535. The advance table is not cleared; entries are undefined
//   until written.
// Stall: while the break register is full and not taken, the input stage holds
//   only if its item would produce a break; other items keep flowing.
`default_nettype none
module greedy_word_wrap (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ggw_char_if.sink   chars,
    ggw_break_if.source breaks,
    ggw_cfg_if.sink    cfg
);
    import ggw_pkg::*;

    logic [ADV_W-1:0]   table_mem [GLYPHS];
    logic [ADV_W-1:0]   rd_reg;

    logic               s1_valid_reg;
    logic               s1_cmd_reg;
    logic               s1_start_reg;
    logic [CODE_W-1:0]  s1_code_reg;
    logic               s1_ok_reg;

    logic               out_valid_reg;
    logic [BREAK_W-1:0] out_pos_reg;
    logic [WIDTH_W-1:0] out_width_reg;

    logic [MAXW_W-1:0]  max_width_reg;

    logic               accept;
    logic               code_ok;
    logic               s1_char;
    logic               s1_has_res;
    logic               s1_go;
    logic [ADV_W-1:0]   adv;
    line_req_t          req;
    line_res_t          res;

    assign code_ok = ({1'b0, chars.code} < (CODE_W + 1)'(GLYPHS));
    assign s1_char = (s1_cmd_reg == CMD_CHAR);
    assign s1_has_res = s1_valid_reg && s1_char && res.hit;
    assign s1_go = s1_valid_reg && (!s1_has_res || !out_valid_reg || breaks.ready);
    assign chars.ready = !s1_valid_reg || s1_go;
    assign accept = chars.valid && chars.ready;

    assign adv = s1_ok_reg ? rd_reg : '0;
    assign req.start = s1_start_reg;
    assign req.code  = s1_code_reg;

    ggw_line u_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_go && s1_char),
        .req       (req),
        .adv       (adv),
        .max_width (max_width_reg),
        .res       (res)
    );

    // advance table: write and read at acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if ((chars.cmd == CMD_TABLE_WRITE) && code_ok)
            begin
                table_mem[chars.code[TABLE_AW-1:0]] <= chars.advance;
            end
            rd_reg <= table_mem[chars.code[TABLE_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= chars.cmd;
            s1_start_reg <= chars.start_req;
            s1_code_reg  <= chars.code;
            s1_ok_reg    <= code_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_has_res)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (breaks.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_has_res)
        begin
            out_pos_reg   <= res.break_pos;
            out_width_reg <= res.line_width;
        end
    end

    assign breaks.valid      = out_valid_reg;
    assign breaks.break_pos  = out_pos_reg;
    assign breaks.line_width = out_width_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg <= MAX_WIDTH_RESET;
        end
        else if (cfg.valid)
        begin
            max_width_reg <= cfg.data;
        end
    end

endmodule
`default_nettype wire
